// ===== rtl/tip_pkg.sv =====
// shared types and constants of the text integer parser
package tip_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int OUT_W          = 32;
    localparam int CHAR_W         = 8;
    localparam int WIDTH_W        = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd1;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CASE_FLIP  = 8'h20;

    typedef enum logic [1:0] {
        BASE_AUTO = 2'd0,
        BASE_DEC  = 2'd1,
        BASE_OCT  = 2'd2,
        BASE_HEX  = 2'd3
    } t_base;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SIGNED = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    typedef struct packed {
        logic       good;
        logic [3:0] val;
    } t_digit;

endpackage

// ===== rtl/tip_digit.sv =====
// digit classifier: character to digit value for the active base
module tip_digit (
    input  logic [tip_pkg::CHAR_W-1:0] i_ch,
    input  tip_pkg::t_base             i_base,
    output tip_pkg::t_digit            o_digit
);

    always_comb begin
        logic [tip_pkg::CHAR_W-1:0] c;
        logic [tip_pkg::CHAR_W-1:0] h;
        c = i_ch - tip_pkg::CH_ZERO;
        h = (c & ~tip_pkg::CASE_FLIP) - 8'd17;
        o_digit.good = 1'b1;
        o_digit.val  = c[3:0];
        if (c > 8'd7) begin
            if (i_base == tip_pkg::BASE_OCT) begin
                o_digit.good = 1'b0;
            end else if (c > 8'd9) begin
                if (i_base != tip_pkg::BASE_HEX) begin
                    o_digit.good = 1'b0;
                end else if (h > 8'd5) begin
                    o_digit.good = 1'b0;
                end else begin
                    o_digit.val = h[3:0] + 4'd10;
                end
            end
        end
    end

endmodule

// ===== rtl/tip_core.sv =====
// parse state machine with shift-add accumulator
module tip_core #(
    parameter int VALUE_BITS = tip_pkg::DEF_VALUE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [tip_pkg::CHAR_W-1:0]  i_ch,
    input  logic                        i_eot,
    input  tip_pkg::t_base              i_base_mode,
    input  logic [tip_pkg::WIDTH_W-1:0] i_max_width,
    output logic                        o_fire,
    output logic [tip_pkg::OUT_W-1:0]   o_value,
    output logic                        o_ok,
    output logic                        o_char_used
);

    tip_pkg::t_phase             r_phase, n_phase;
    logic [VALUE_BITS-1:0]       r_acc, n_acc;
    logic [tip_pkg::WIDTH_W-1:0] r_wl, n_wl;
    logic                        r_neg, n_neg;
    logic                        r_seen, n_seen;
    tip_pkg::t_base              r_base, n_base;

    tip_pkg::t_base              base_cur;
    tip_pkg::t_base              base_dig;
    logic [tip_pkg::WIDTH_W-1:0] wl_cur;
    logic [tip_pkg::WIDTH_W-1:0] wl_take;
    logic                        wl_done;
    tip_pkg::t_digit             dig;
    logic [VALUE_BITS-1:0]       acc_shift;
    logic [VALUE_BITS-1:0]       acc_dig;
    logic [VALUE_BITS-1:0]       fin_acc;
    logic [VALUE_BITS-1:0]       fin_signed;
    logic [VALUE_BITS+tip_pkg::OUT_W-1:0] fin_ext;
    logic                        do_first;
    logic                        do_digit;

    // a new number picks up the current registers
    assign base_cur = (r_phase == tip_pkg::PH_START) ? i_base_mode : r_base;
    assign wl_cur   = (r_phase == tip_pkg::PH_START) ? i_max_width : r_wl;
    assign base_dig = (r_phase == tip_pkg::PH_ZERO && base_cur != tip_pkg::BASE_HEX)
                    ? tip_pkg::BASE_OCT : base_cur;

    assign wl_take = (wl_cur == '0) ? '0 : wl_cur - 8'd1;
    assign wl_done = (wl_cur == 8'd1);

    tip_digit u_digit (
        .i_ch    (i_ch),
        .i_base  (base_dig),
        .o_digit (dig)
    );

    always_comb begin
        case (base_dig)
            tip_pkg::BASE_OCT: acc_shift = {r_acc[VALUE_BITS-4:0], 3'b000};
            tip_pkg::BASE_HEX: acc_shift = {r_acc[VALUE_BITS-5:0], 4'b0000};
            default:           acc_shift = {r_acc[VALUE_BITS-4:0], 3'b000}
                                         + {r_acc[VALUE_BITS-2:0], 1'b0};
        endcase
    end

    assign acc_dig = acc_shift + {{(VALUE_BITS-4){1'b0}}, dig.val};

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_wl        = wl_cur;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_base      = base_cur;
        o_fire      = 1'b0;
        o_ok        = 1'b0;
        o_char_used = 1'b0;
        fin_acc     = r_acc;
        do_first    = 1'b0;
        do_digit    = 1'b0;

        case (r_phase)
            tip_pkg::PH_START: begin
                if (i_eot) begin
                    o_fire = 1'b1;
                end else if (i_ch inside {tip_pkg::CH_MINUS, tip_pkg::CH_PLUS}) begin
                    n_neg = (i_ch == tip_pkg::CH_MINUS);
                    n_wl  = wl_take;
                    if (wl_done) begin
                        // width gone on the sign alone
                        o_fire      = 1'b1;
                        o_char_used = 1'b1;
                    end else begin
                        n_phase = tip_pkg::PH_SIGNED;
                    end
                end else begin
                    do_first = 1'b1;
                end
            end
            tip_pkg::PH_SIGNED: begin
                if (i_eot) begin
                    o_fire = 1'b1;
                end else begin
                    do_first = 1'b1;
                end
            end
            tip_pkg::PH_ZERO: begin
                if (i_eot) begin
                    o_fire = 1'b1;
                    o_ok   = 1'b1;
                end else if (i_ch inside {tip_pkg::CH_LOWER_X, tip_pkg::CH_UPPER_X}) begin
                    n_base = tip_pkg::BASE_HEX;
                    n_wl   = wl_take;
                    if (wl_done) begin
                        o_fire      = 1'b1;
                        o_ok        = 1'b1;
                        o_char_used = 1'b1;
                    end else begin
                        n_phase = tip_pkg::PH_DIGITS;
                    end
                end else begin
                    n_base   = base_dig;
                    do_digit = 1'b1;
                end
            end
            default: begin
                if (i_eot) begin
                    o_fire = 1'b1;
                    o_ok   = r_seen;
                end else begin
                    do_digit = 1'b1;
                end
            end
        endcase

        if (do_first) begin
            // leading zero is a prefix only in auto and hex modes
            if ((base_cur inside {tip_pkg::BASE_AUTO, tip_pkg::BASE_HEX})
                && i_ch == tip_pkg::CH_ZERO) begin
                n_seen = 1'b1;
                n_wl   = wl_take;
                if (wl_done) begin
                    o_fire      = 1'b1;
                    o_ok        = 1'b1;
                    o_char_used = 1'b1;
                end else begin
                    n_phase = tip_pkg::PH_ZERO;
                end
            end else begin
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            if (!dig.good) begin
                o_fire = 1'b1;
                o_ok   = r_seen;
            end else begin
                n_acc   = acc_dig;
                fin_acc = acc_dig;
                n_seen  = 1'b1;
                n_wl    = wl_take;
                if (wl_done) begin
                    o_fire      = 1'b1;
                    o_ok        = 1'b1;
                    o_char_used = 1'b1;
                end else begin
                    n_phase = tip_pkg::PH_DIGITS;
                end
            end
        end

        if (o_fire) begin
            n_phase = tip_pkg::PH_START;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_seen  = 1'b0;
        end
    end

    assign fin_signed = r_neg ? ('0 - fin_acc) : fin_acc;
    assign fin_ext    = {{tip_pkg::OUT_W{1'b0}}, (o_ok ? fin_signed : '0)};
    assign o_value    = fin_ext[tip_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tip_pkg::PH_START;
            r_acc   <= '0;
            r_wl    <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_base  <= tip_pkg::BASE_AUTO;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_wl    <= n_wl;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_base  <= n_base;
        end
    end

endmodule

// ===== rtl/text_integer_parser.sv =====
// text integer parser top level: input register, parse step, result register
// the result word is registered in the result slot by the step that ends its number
// throughput: one character word per cycle while no result word waits under i_stall
// a character that ends no number yields no result word
// reset (synchronous, active low) clears both stages, the parse state and the
// registers to auto base and unlimited width
module text_integer_parser #(
    parameter int VALUE_BITS = tip_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // character channel
    input  logic                           i_valid,
    input  logic [tip_pkg::CHAR_W-1:0]     i_ch,
    input  logic                           i_end_of_text,
    output logic                           o_stall,
    // result channel
    output logic                           o_valid,
    output logic [tip_pkg::OUT_W-1:0]      o_value,
    output logic                           o_ok,
    output logic                           o_char_used,
    input  logic                           i_stall,
    // register write channel
    input  logic                           i_cfg_valid,
    input  logic [tip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready
);

    // configuration registers
    tip_pkg::t_base              r_base_mode;
    logic [tip_pkg::WIDTH_W-1:0] r_max_width;

    // input register
    logic                        r_in_valid;
    logic [tip_pkg::CHAR_W-1:0]  r_in_ch;
    logic                        r_in_eot;

    // result register
    logic                        r_out_valid;
    logic [tip_pkg::OUT_W-1:0]   r_out_value;
    logic                        r_out_ok;
    logic                        r_out_used;

    logic                        step;
    logic                        fire;
    logic [tip_pkg::OUT_W-1:0]   step_value;
    logic                        step_ok;
    logic                        step_used;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mode <= tip_pkg::BASE_AUTO;
            r_max_width <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tip_pkg::CFG_BASE_MODE: r_base_mode <= tip_pkg::t_base'(i_cfg_data[1:0]);
                tip_pkg::CFG_MAX_WIDTH: r_max_width <= i_cfg_data[tip_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // the held character moves through the parse step when the result slot
    // is empty or its word is taken in the same cycle; while a result word
    // waits under i_stall every held character waits, whether it ends a
    // number or not
    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_ch  <= i_ch;
            r_in_eot <= i_end_of_text;
        end
    end

    tip_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (r_in_ch),
        .i_eot       (r_in_eot),
        .i_base_mode (r_base_mode),
        .i_max_width (r_max_width),
        .o_fire      (fire),
        .o_value     (step_value),
        .o_ok        (step_ok),
        .o_char_used (step_used)
    );

    // result slot: filled by a finishing step, emptied when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && fire) begin
            r_out_value <= step_value;
            r_out_ok    <= step_ok;
            r_out_used  <= step_used;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_ok        = r_out_ok;
    assign o_char_used = r_out_used;

    // a failed conversion always reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_value == '0)
        else $error("error result carries a nonzero value");

    // a held character is neither dropped nor changed while the result slot blocks
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_ch) && $stable(r_in_eot))
        else $error("held character lost while stalled");

    // a waiting result is never overwritten or dropped
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out_value) && $stable(r_out_ok))
        else $error("waiting result lost or overwritten");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the text integer parser: directed number table, then random number streams
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CHARS = 1500;  // character words in the random part
    localparam int PHASE_CHARS  = 125;   // character words per register setting
    localparam int PIPE_PAD     = 4;     // padding that covers the input and result registers, plus margin
    localparam int GAP_MAX      = 6;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no word moving anywhere

    // 'A' - '0': offset of the hex letters once folded to upper case
    localparam logic [7:0] HEX_LETTER_OFS = 8'h11;

    typedef struct packed {
        logic [tip_pkg::CHAR_W-1:0] ch;
        logic                       eot;
    } t_char;

    typedef struct packed {
        logic [tip_pkg::OUT_W-1:0] value;
        logic                      ok;
        logic                      used;
    } t_result;

    typedef enum logic {ROW_TEXT, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind                      kind;
        string                          text;
        bit                             eot;     // end of text after the characters
        logic [tip_pkg::CFG_IDX_W-1:0]  idx;
        logic [tip_pkg::CFG_DATA_W-1:0] data;
        bit                             checked; // row ends in one known result
        t_result                        want;
    } t_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // dut ports
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic [tip_pkg::CHAR_W-1:0]     i_ch;
    logic                           i_end_of_text;
    logic                           o_stall;
    logic                           o_valid;
    logic [tip_pkg::OUT_W-1:0]      o_value;
    logic                           o_ok;
    logic                           o_char_used;
    logic                           i_stall = 1'b0;
    logic                           i_cfg_valid;
    logic [tip_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tip_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           o_cfg_ready;

    text_integer_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ch          (i_ch),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_ok          (o_ok),
        .o_char_used   (o_char_used),
        .i_stall       (i_stall),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready)
    );

    // register copies and parse state of the predictor
    tip_pkg::t_base  reg_base;
    logic [7:0]      reg_width;
    tip_pkg::t_phase num_phase;
    logic [31:0]     num_acc;
    logic [7:0]      width_left;
    bit              num_neg;
    bit              num_digit_seen;
    tip_pkg::t_base  num_base;

    t_result     awaited_numbers[$];
    t_char       char_plan[$];
    t_row        directed_rows[$];

    int          errors        = 0;
    int          chars_sent    = 0;
    int          results_seen  = 0;
    int          failed_conv   = 0;
    int          reg_writes    = 0;
    int          idle_cycles   = 0;
    int          burst_left    = 0;
    bit          no_gaps       = 1'b0;
    t_stall_mode stall_mode    = STALL_NONE;
    int          stall_period  = 4;
    int          stall_duty    = 1;
    int          stall_tick    = 0;
    string       end_marks     = " ,;/:@Gg89aF";

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // emits the finished number and rearms from the current registers
    function automatic t_result close_number(bit ok, bit used);
        t_result r;
        r.value        = ok ? (num_neg ? 32'd0 - num_acc : num_acc) : '0;
        r.ok           = ok;
        r.used         = used;
        num_phase      = tip_pkg::PH_START;
        num_acc        = '0;
        width_left     = reg_width;
        num_neg        = 1'b0;
        num_digit_seen = 1'b0;
        num_base       = reg_base;
        return r;
    endfunction

    // charges one character to the field width; true once it is used up
    function automatic bit count_char();
        if (width_left != 8'd0) begin
            width_left = width_left - 8'd1;
            return width_left == 8'd0;
        end
        return 1'b0;
    endfunction

    function automatic bit take_digit(logic [7:0] ch, output t_result r);
        logic [7:0] d;
        bit         good;
        r    = '0;
        d    = ch - tip_pkg::CH_ZERO;
        good = 1'b1;
        if (d > 8'd7) begin
            if (num_base == tip_pkg::BASE_OCT) begin
                good = 1'b0;
            end else if (d > 8'd9) begin
                if (num_base != tip_pkg::BASE_HEX) begin
                    good = 1'b0;
                end else begin
                    d = (d & ~tip_pkg::CASE_FLIP) - HEX_LETTER_OFS;
                    if (d > 8'd5)
                        good = 1'b0;
                    else
                        d = d + 8'd10;
                end
            end
        end
        // anything that is not a digit ends the number and stays unread
        if (!good) begin
            r = close_number(num_digit_seen, 1'b0);
            return 1'b1;
        end
        case (num_base)
            tip_pkg::BASE_OCT: num_acc = num_acc << 3;
            tip_pkg::BASE_HEX: num_acc = num_acc << 4;
            default:           num_acc = num_acc * 32'd10;
        endcase
        num_acc        = num_acc + {24'd0, d};
        num_digit_seen = 1'b1;
        if (count_char()) begin
            r = close_number(1'b1, 1'b1);
            return 1'b1;
        end
        num_phase = tip_pkg::PH_DIGITS;
        return 1'b0;
    endfunction

    // first character after the optional sign: a '0' may open a base prefix
    function automatic bit lead_char(logic [7:0] ch, output t_result r);
        r = '0;
        if (!(num_base inside {tip_pkg::BASE_DEC, tip_pkg::BASE_OCT})
            && ch == tip_pkg::CH_ZERO) begin
            num_digit_seen = 1'b1;
            if (count_char()) begin
                r = close_number(1'b1, 1'b1);
                return 1'b1;
            end
            num_phase = tip_pkg::PH_ZERO;
            return 1'b0;
        end
        return take_digit(ch, r);
    endfunction

    // one accepted character word; true when it completes a number
    function automatic bit parse_char(t_char w, output t_result r);
        r = '0;
        case (num_phase)
            tip_pkg::PH_START: begin
                width_left = reg_width;
                num_base   = reg_base;
                if (w.eot) begin
                    r = close_number(1'b0, 1'b0);
                    return 1'b1;
                end
                if (w.ch inside {tip_pkg::CH_MINUS, tip_pkg::CH_PLUS}) begin
                    num_neg = (w.ch == tip_pkg::CH_MINUS);
                    if (count_char()) begin
                        r = close_number(1'b0, 1'b1);
                        return 1'b1;
                    end
                    num_phase = tip_pkg::PH_SIGNED;
                    return 1'b0;
                end
                return lead_char(w.ch, r);
            end
            tip_pkg::PH_SIGNED: begin
                if (w.eot) begin
                    r = close_number(1'b0, 1'b0);
                    return 1'b1;
                end
                return lead_char(w.ch, r);
            end
            tip_pkg::PH_ZERO: begin
                if (w.eot) begin
                    r = close_number(1'b1, 1'b0);
                    return 1'b1;
                end
                if (w.ch inside {tip_pkg::CH_LOWER_X, tip_pkg::CH_UPPER_X}) begin
                    num_base = tip_pkg::BASE_HEX;
                    if (count_char()) begin
                        r = close_number(1'b1, 1'b1);
                        return 1'b1;
                    end
                    num_phase = tip_pkg::PH_DIGITS;
                    return 1'b0;
                end
                if (num_base != tip_pkg::BASE_HEX)
                    num_base = tip_pkg::BASE_OCT;
                return take_digit(w.ch, r);
            end
            default: begin
                if (w.eot) begin
                    r = close_number(num_digit_seen, 1'b0);
                    return 1'b1;
                end
                return take_digit(w.ch, r);
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_char as_char(logic [7:0] c, bit e);
        t_char w;
        w.ch  = c;
        w.eot = e;
        return w;
    endfunction

    function automatic t_row text_row(string s, bit e, bit chk, t_result want);
        t_row row;
        row.kind    = ROW_TEXT;
        row.text    = s;
        row.eot     = e;
        row.idx     = tip_pkg::CFG_BASE_MODE;
        row.data    = '0;
        row.checked = chk;
        row.want    = want;
        return row;
    endfunction

    function automatic t_row reg_row(logic [tip_pkg::CFG_IDX_W-1:0] idx,
                                     logic [tip_pkg::CFG_DATA_W-1:0] data);
        t_row row;
        row         = text_row("", 1'b0, 1'b0, '0);
        row.kind    = ROW_REG;
        row.idx     = idx;
        row.data    = data;
        return row;
    endfunction

    // queues one number shaped for the current base, or a short burst of noise
    function automatic void plan_number();
        int             n;
        int             sel;
        bit             lead_dec;
        tip_pkg::t_base b;
        logic [7:0]     c;
        logic [7:0]     v;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                char_plan.push_back(as_char(8'($urandom), $urandom_range(0, 7) == 0));
            return;
        end
        sel = $urandom_range(0, 3);
        if (sel == 0)
            char_plan.push_back(as_char(tip_pkg::CH_MINUS, 1'b0));
        else if (sel == 1)
            char_plan.push_back(as_char(tip_pkg::CH_PLUS, 1'b0));
        b        = reg_base;
        lead_dec = 1'b0;
        if (reg_base == tip_pkg::BASE_AUTO) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) begin
                b        = tip_pkg::BASE_DEC;
                lead_dec = 1'b1;
            end else begin
                char_plan.push_back(as_char(tip_pkg::CH_ZERO, 1'b0));
                b = tip_pkg::BASE_OCT;
                if (sel == 2) begin
                    char_plan.push_back(as_char($urandom_range(0, 1) ? tip_pkg::CH_LOWER_X
                                                                     : tip_pkg::CH_UPPER_X,
                                                1'b0));
                    b = tip_pkg::BASE_HEX;
                end
            end
        end else if (reg_base == tip_pkg::BASE_HEX && $urandom_range(0, 1) == 1) begin
            char_plan.push_back(as_char(tip_pkg::CH_ZERO, 1'b0));
            char_plan.push_back(as_char($urandom_range(0, 1) ? tip_pkg::CH_LOWER_X
                                                             : tip_pkg::CH_UPPER_X, 1'b0));
        end
        // a few numbers carry no digit at all
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            case (b)
                tip_pkg::BASE_OCT: c = tip_pkg::CH_ZERO + 8'($urandom_range(0, 7));
                tip_pkg::BASE_HEX: begin
                    v = 8'($urandom_range(0, 15));
                    // letters in either case, 'a' or 'A' onward
                    c = (v < 8'd10) ? tip_pkg::CH_ZERO + v
                                    : ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
                end
                default: begin
                    if (lead_dec && k == 0)
                        c = tip_pkg::CH_ZERO + 8'($urandom_range(1, 9));
                    else
                        c = tip_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                end
            endcase
            char_plan.push_back(as_char(c, 1'b0));
        end
        sel = $urandom_range(0, 9);
        if (sel < 4)
            char_plan.push_back(as_char(8'($urandom), 1'b1));
        else if (sel < 7)
            char_plan.push_back(as_char(end_marks[$urandom_range(0, end_marks.len() - 1)], 1'b0));
        else if (sel == 7)
            char_plan.push_back(as_char(8'($urandom), 1'b0));
        // otherwise the width limit or the next number ends it
    endfunction

    // ---------------------------------------------------------------- drivers

    // sender works in bursts; starts and ends at a falling edge
    task automatic send_char(input t_char w, output bit got, output t_result r);
        if (!no_gaps && burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid       <= 1'b1;
        i_ch          <= w.ch;
        i_end_of_text <= w.eot;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        burst_left--;
        got = parse_char(w, r);
        if (got)
            awaited_numbers.push_back(r);
        @(negedge i_clk);
    endtask

    // lets every awaited result arrive, then covers the pipeline depth
    task automatic drain();
        i_valid <= 1'b0;
        while (awaited_numbers.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_PAD) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tip_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == tip_pkg::CFG_BASE_MODE)
            reg_base = tip_pkg::t_base'(data[1:0]);
        else if (idx == tip_pkg::CFG_MAX_WIDTH)
            reg_width = data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver stall pattern, set per register setting
    always @(negedge i_clk) begin
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
            default:     i_stall <= ((stall_tick % stall_period) < stall_duty);
        endcase
    end

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- result check and watchdog

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (!o_ok)
                    failed_conv++;
                if (awaited_numbers.size() == 0) begin
                    errors++;
                    $display("%0t: result word with none awaited, expected nothing, got %h/%b/%b",
                             $time, o_value, o_ok, o_char_used);
                end else begin
                    want = awaited_numbers.pop_front();
                    check_field("value", want.value, o_value);
                    check_field("ok", 32'(want.ok), 32'(o_ok));
                    check_field("char_used", 32'(want.used), 32'(o_char_used));
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d results still awaited",
                         $time, idle_cycles, awaited_numbers.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_row           row;
        t_char          w;
        t_char          row_chars[$];
        bit             got;
        t_result        r;
        t_result        last_r;
        int             n_res;
        int             ph;
        int             rand_start;
        int             phase_start;
        tip_pkg::t_base b;
        logic [7:0]     wd;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ch          = '0;
        i_end_of_text = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = tip_pkg::CFG_BASE_MODE;
        i_cfg_data    = '0;
        reg_base      = tip_pkg::BASE_AUTO;
        reg_width     = 8'd0;
        void'(close_number(1'b0, 1'b0));

        // reset state: auto base, unlimited width
        directed_rows.push_back(text_row("", 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(text_row("-", 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}));
        directed_rows.push_back(text_row("42,", 1'b0, 1'b1, '{32'd42, 1'b1, 1'b0}));
        directed_rows.push_back(text_row("-0xFf", 1'b1, 1'b0, '0));
        // leading zero picks octal, so the '8' ends the number
        directed_rows.push_back(text_row("078", 1'b0, 1'b1, '{32'd7, 1'b1, 1'b0}));
        directed_rows.push_back(text_row("0", 1'b1, 1'b1, '{32'd0, 1'b1, 1'b0}));
        directed_rows.push_back(text_row("+z", 1'b0, 1'b1, '{32'd0, 1'b0, 1'b0}));
        // one-character field: the sign alone fails, a digit alone succeeds
        directed_rows.push_back(reg_row(tip_pkg::CFG_MAX_WIDTH, 8'd1));
        directed_rows.push_back(text_row("-", 1'b0, 1'b1, '{32'd0, 1'b0, 1'b1}));
        directed_rows.push_back(text_row("9", 1'b0, 1'b1, '{32'd9, 1'b1, 1'b1}));
        directed_rows.push_back(reg_row(tip_pkg::CFG_MAX_WIDTH, 8'd255));
        directed_rows.push_back(reg_row(tip_pkg::CFG_BASE_MODE, {6'h3F, tip_pkg::BASE_OCT}));
        // base change lands mid-number and must wait for the next one
        directed_rows.push_back(text_row("1", 1'b0, 1'b0, '0));
        directed_rows.push_back(reg_row(tip_pkg::CFG_BASE_MODE, {6'h00, tip_pkg::BASE_HEX}));
        directed_rows.push_back(text_row("a", 1'b0, 1'b1, '{32'd1, 1'b1, 1'b0}));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        stall_mode = STALL_LIGHT;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG) begin
                drain();
                write_reg(row.idx, row.data);
            end else begin
                row_chars.delete();
                for (int j = 0; j < row.text.len(); j++)
                    row_chars.push_back(as_char(row.text[j], 1'b0));
                if (row.eot)
                    row_chars.push_back(as_char(8'($urandom), 1'b1));
                n_res  = 0;
                last_r = '0;
                foreach (row_chars[j]) begin
                    send_char(row_chars[j], got, r);
                    if (got) begin
                        n_res++;
                        last_r = r;
                    end
                end
                if (row.checked && (n_res != 1 || last_r !== row.want)) begin
                    errors++;
                    $display("%0t: directed row %0d, expected %h/%b/%b, got %0d results, %s",
                             $time, k, row.want.value, row.want.ok, row.want.used,
                             n_res, $sformatf("last %h/%b/%b",
                                              last_r.value, last_r.ok, last_r.used));
                end
            end
        end

        // random part: each setting gets its own base, width and idle pattern
        rand_start = chars_sent;
        ph = 0;
        while (chars_sent - rand_start < RANDOM_CHARS) begin
            drain();
            b = (ph < 8) ? tip_pkg::t_base'(ph % 4) : tip_pkg::t_base'($urandom_range(0, 3));
            case (ph % 6)
                0:       wd = 8'd0;
                1:       wd = 8'd255;
                2:       wd = 8'd1;
                3:       wd = 8'($urandom_range(2, 4));
                4:       wd = 8'($urandom_range(5, 20));
                default: wd = 8'($urandom);
            endcase
            write_reg(tip_pkg::CFG_BASE_MODE, {6'($urandom), b});
            write_reg(tip_pkg::CFG_MAX_WIDTH, wd);
            no_gaps      = (ph % 5 == 3);
            stall_mode   = (ph < 4) ? t_stall_mode'(ph) : t_stall_mode'($urandom_range(0, 3));
            stall_period = $urandom_range(2, 9);
            stall_duty   = $urandom_range(1, stall_period - 1);
            phase_start  = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                if (char_plan.size() == 0)
                    plan_number();
                w = char_plan.pop_front();
                send_char(w, got, r);
            end
            char_plan.delete();
            ph++;
        end

        drain();
        repeat (2 * PIPE_PAD) @(posedge i_clk);

        $display("covered %0d character words over %0d random settings, %0d register writes",
                 chars_sent, ph, reg_writes);
        $display("checked %0d result words, %0d of them failed conversions",
                 results_seen, failed_conv);
        if (errors == 0 && awaited_numbers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
